### sv/ssched_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssched_pkg
// Shared constants, codes and types of the stride scheduler.
// ----------------------------------------------------------------------------
package ssched_pkg;

   localparam int CLIENTS    = 16;
   localparam int SLOT_W     = 4;
   localparam int LEN_W      = 5;
   localparam int STRIDE_ONE = 32768;
   localparam int TOTAL_W    = 21;
   localparam int PROD_W     = 48;
   localparam int DIVR_W     = 21;
   localparam int DIV_STEPS  = 48;
   localparam int CNT_W      = 6;

   localparam logic [2:0] MODE_NEW       = 3'd0;
   localparam logic [2:0] MODE_UNBLOCK   = 3'd1;
   localparam logic [2:0] MODE_SET_TICK  = 3'd2;
   localparam logic [2:0] MODE_EXIT      = 3'd3;
   localparam logic [2:0] MODE_PICK      = 3'd4;
   localparam logic [2:0] MODE_BLOCKED   = 3'd5;
   localparam logic [2:0] MODE_REQUEUE   = 3'd6;
   localparam logic [2:0] MODE_NOT_READY = 3'd7;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_UNKNOWN    = 3'd1;
   localparam logic [2:0] ST_ZERO_TICK  = 3'd2;
   localparam logic [2:0] ST_SLOT_USED  = 3'd3;
   localparam logic [2:0] ST_NO_CURRENT = 3'd4;

   localparam logic REG_QUANTUM  = 1'b0;
   localparam logic REG_PEDANTIC = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [3:0]  slot;
      logic [15:0] tickets;
      logic [31:0] now;
      logic [30:0] run_time;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] chosen_slot;
      logic       chosen_valid;
      logic       wake_on_block;
      logic [4:0] queued_count;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [31:0]       pass;
   } cell_data_type;

   typedef struct packed {
      logic              put;
      logic              take;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       pass;
   } cell_ctl_type;

endpackage

### sv/ssched_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssched_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssched_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ssched_pkg::PROD_W-1:0] dividend,
   input  logic [ssched_pkg::DIVR_W-1:0] divisor,
   output logic                          done,
   output logic [ssched_pkg::PROD_W-1:0] quotient
);
   import ssched_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] dvd_ff, dvd_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] dvs_ff, dvs_in;
   logic [DIVR_W:0]   trial;
   logic              qbit;

   always_comb begin
      trial  = {rem_ff, dvd_ff[PROD_W-1]};
      qbit   = trial >= {1'b0, dvs_ff};
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[PROD_W-2:0], qbit};
         rem_in = qbit ? DIVR_W'(trial - {1'b0, dvs_ff}) : trial[DIVR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

### sv/ssched_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssched_cell
// One run queue entry: sorted insert shifts right, removal shifts left.
// ----------------------------------------------------------------------------
module ssched_cell (
   input  logic                      clock,
   input  ssched_pkg::cell_ctl_type  ctl,
   input  logic                      valid,
   input  ssched_pkg::cell_data_type left_data,
   input  ssched_pkg::cell_data_type right_data,
   input  logic                      chain_in,
   output ssched_pkg::cell_data_type data,
   output logic                      chain_out
);
   import ssched_pkg::*;

   cell_data_type data_ff, data_in;
   logic          hit;

   always_comb begin
      if (ctl.put) begin
         hit = !valid || ($signed(ctl.pass) <= $signed(data_ff.pass));
      end else begin
         hit = valid && (data_ff.slot == ctl.slot);
      end
      chain_out = chain_in | hit;
      data_in   = data_ff;
      if (ctl.put) begin
         if (chain_in) begin
            data_in = left_data;
         end else if (hit) begin
            data_in = '{slot: ctl.slot, pass: ctl.pass};
         end
      end else if (ctl.take && chain_out) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### sv/stride_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stride_scheduler_core
// Proportional-share stride scheduler with a sorted run queue of cells.
// ----------------------------------------------------------------------------
// steps: rejected, ignored and not ready requests run no steps, a pick runs
// only the take step; each step multiplies, divides in the bit-serial divider
// where needed, then applies; a set-tickets on a queued client runs the most steps
// throughput: one request at a time, accepted only in the idle state
// reset: synchronous, clears queue, slot flags, globals, current client;
// quantum resets to 11 and pedantic to 1
module stride_scheduler_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ssched_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ssched_pkg::rsp_type rsp_payload,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import ssched_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DISP  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DIVGO = 3'd3;
   localparam logic [2:0] S_WAIT  = 3'd4;
   localparam logic [2:0] S_APPLY = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   localparam int OPS = 11;
   localparam logic [3:0] OP_NS    = 4'd0;
   localparam logic [3:0] OP_TAKE  = 4'd1;
   localparam logic [3:0] OP_SYNC1 = 4'd2;
   localparam logic [3:0] OP_REM   = 4'd3;
   localparam logic [3:0] OP_SUB   = 4'd4;
   localparam logic [3:0] OP_MOD   = 4'd5;
   localparam logic [3:0] OP_SYNC2 = 4'd6;
   localparam logic [3:0] OP_PASS  = 4'd7;
   localparam logic [3:0] OP_ADD   = 4'd8;
   localparam logic [3:0] OP_RQ    = 4'd9;
   localparam logic [3:0] OP_PUT   = 4'd10;

   // configuration
   logic [15:0] quantum_ff, quantum_in;
   logic        pedantic_ff, pedantic_in;
   logic [15:0] qeff;

   // control
   logic [2:0]        state_ff, state_in;
   logic [3:0]        op_ff, op_in;
   logic [OPS-1:0]    pend_ff, pend_in;
   logic [SLOT_W-1:0] ws_ff, ws_in;
   logic [15:0]       t_ff, t_in;
   logic [31:0]       now_ff, now_in;
   logic [30:0]       rt_ff, rt_in;
   logic              fresh_ff, fresh_in;
   logic [15:0]       ns_ff, ns_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              neg_ff, neg_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // scheduler state
   logic [CLIENTS-1:0] inuse_ff, inuse_in;
   logic [CLIENTS-1:0] queued_ff, queued_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [15:0]        gstride_ff, gstride_in;
   logic [31:0]        gpass_ff, gpass_in;
   logic [31:0]        last_ff, last_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic               cv_ff, cv_in;

   logic [15:0] tick_ff   [CLIENTS];
   logic [15:0] stride_ff [CLIENTS];
   logic [31:0] pass_ff   [CLIENTS];
   logic [31:0] remain_ff [CLIENTS];

   logic        mod_we;
   logic        pass_we, remain_we;
   logic [31:0] pass_wd, remain_wd;

   // arithmetic
   logic [15:0]       mul_a;
   logic [31:0]       mul_b;
   logic              mul_neg;
   logic [31:0]       el;
   logic [31:0]       rv;
   logic              div_start, div_done;
   logic [DIVR_W-1:0] divisor;
   logic [PROD_W-1:0] quo, squo;
   logic              is_div;
   logic [3:0]        sel;

   // run queue cells
   cell_ctl_type  ctl;
   cell_data_type cdata [CLIENTS];
   logic [CLIENTS-1:0] chain;

   req_type           r;
   logic [SLOT_W-1:0] rs;
   logic              q_s, cur_s;

   assign qeff = (quantum_ff == '0) ? 16'd1 : quantum_ff;

   ssched_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quo)
   );

   for (genvar i = 0; i < CLIENTS; i++) begin : g_cell
      cell_data_type lft, rgt;
      logic          cin;
      if (i == 0) begin : g_first
         assign lft = '{slot: ctl.slot, pass: ctl.pass};
         assign cin = 1'b0;
      end else begin : g_mid
         assign lft = cdata[i-1];
         assign cin = chain[i-1];
      end
      if (i == CLIENTS - 1) begin : g_last
         assign rgt = cdata[i];
      end else begin : g_inner
         assign rgt = cdata[i+1];
      end
      ssched_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .valid      (LEN_W'(i) < len_ff),
         .left_data  (lft),
         .right_data (rgt),
         .chain_in   (cin),
         .data       (cdata[i]),
         .chain_out  (chain[i])
      );
   end

   assign squo = neg_ff ? (~quo + 1'b1) : quo;

   always_comb begin
      r     = req_payload;
      rs    = r.slot;
      q_s   = queued_ff[rs];
      cur_s = cv_ff && (cur_ff == rs);
      el    = now_ff - last_ff;
      rv    = remain_ff[ws_ff];
      is_div = (op_ff == OP_NS) || (op_ff == OP_SYNC1) || (op_ff == OP_SYNC2) ||
               (op_ff == OP_SUB) || (op_ff == OP_ADD) || (op_ff == OP_MOD) ||
               (op_ff == OP_RQ);

      mul_a   = 16'd1;
      mul_b   = 32'(STRIDE_ONE);
      mul_neg = 1'b0;
      case (op_ff)
         OP_SYNC1, OP_SYNC2: begin
            mul_a   = gstride_ff;
            mul_neg = el[31];
            mul_b   = el[31] ? (~el + 1'b1) : el;
         end
         OP_MOD: begin
            mul_a   = ns_ff;
            mul_neg = rv[31];
            mul_b   = rv[31] ? (~rv + 1'b1) : rv;
         end
         OP_RQ: begin
            mul_a = stride_ff[ws_ff];
            mul_b = {1'b0, rt_ff};
         end
         default: begin
            mul_a = 16'd1;
         end
      endcase

      case (op_ff)
         OP_NS:               divisor = DIVR_W'(t_ff);
         OP_SUB, OP_ADD:      divisor = total_ff;
         OP_MOD:              divisor = fresh_ff ? '0 : DIVR_W'(stride_ff[ws_ff]);
         default:             divisor = DIVR_W'(qeff);
      endcase

      sel = '0;
      for (int k = OPS - 1; k >= 0; k--) begin
         if (pend_ff[k]) begin
            sel = 4'(k);
         end
      end

      state_in   = state_ff;
      op_in      = op_ff;
      pend_in    = pend_ff;
      ws_in      = ws_ff;
      t_in       = t_ff;
      now_in     = now_ff;
      rt_in      = rt_ff;
      fresh_in   = fresh_ff;
      ns_in      = ns_ff;
      prod_in    = prod_ff;
      neg_in     = neg_ff;
      res_in     = res_ff;
      rsp_in     = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      inuse_in   = inuse_ff;
      queued_in  = queued_ff;
      len_in     = len_ff;
      total_in   = total_ff;
      gstride_in = gstride_ff;
      gpass_in   = gpass_ff;
      last_in    = last_ff;
      cur_in     = cur_ff;
      cv_in      = cv_ff;
      mod_we     = 1'b0;
      pass_we    = 1'b0;
      remain_we  = 1'b0;
      pass_wd    = '0;
      remain_wd  = '0;
      div_start  = 1'b0;
      ctl        = '0;
      ctl.slot   = ws_ff;
      ctl.pass   = pass_ff[ws_ff];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DISP;
               ws_in    = rs;
               t_in     = r.tickets;
               now_in   = r.now;
               rt_in    = r.run_time;
               fresh_in = 1'b0;
               pend_in  = '0;
               res_in   = '0;
               if ((r.mode == MODE_UNBLOCK || r.mode == MODE_SET_TICK ||
                    r.mode == MODE_EXIT) && !inuse_ff[rs]) begin
                  res_in.status = ST_UNKNOWN;
               end else begin
                  unique case (r.mode)
                     MODE_NEW: begin
                        if (inuse_ff[rs]) begin
                           res_in.status = ST_SLOT_USED;
                        end else if (r.tickets == '0) begin
                           res_in.status = ST_ZERO_TICK;
                        end else begin
                           inuse_in[rs] = 1'b1;
                           fresh_in = 1'b1;
                           pend_in[OP_NS]    = 1'b1;
                           pend_in[OP_MOD]   = 1'b1;
                           pend_in[OP_SYNC2] = 1'b1;
                           pend_in[OP_PASS]  = 1'b1;
                           pend_in[OP_ADD]   = 1'b1;
                           pend_in[OP_PUT]   = 1'b1;
                        end
                     end
                     MODE_UNBLOCK: begin
                        if (!q_s && !cur_s) begin
                           pend_in[OP_SYNC2] = 1'b1;
                           pend_in[OP_PASS]  = 1'b1;
                           pend_in[OP_ADD]   = 1'b1;
                           pend_in[OP_PUT]   = 1'b1;
                        end
                     end
                     MODE_SET_TICK: begin
                        if (r.tickets == '0) begin
                           res_in.status = ST_ZERO_TICK;
                        end else begin
                           pend_in[OP_NS]  = 1'b1;
                           pend_in[OP_MOD] = 1'b1;
                           if (q_s) begin
                              pend_in[OP_TAKE]  = 1'b1;
                              pend_in[OP_SYNC1] = 1'b1;
                              pend_in[OP_REM]   = 1'b1;
                              pend_in[OP_SUB]   = 1'b1;
                              pend_in[OP_SYNC2] = 1'b1;
                              pend_in[OP_PASS]  = 1'b1;
                              pend_in[OP_ADD]   = 1'b1;
                              pend_in[OP_PUT]   = 1'b1;
                           end else if (cur_s) begin
                              pend_in[OP_SUB] = 1'b1;
                              pend_in[OP_ADD] = 1'b1;
                           end
                        end
                     end
                     MODE_EXIT: begin
                        if (q_s) begin
                           pend_in[OP_TAKE]  = 1'b1;
                           pend_in[OP_SYNC1] = 1'b1;
                           pend_in[OP_REM]   = 1'b1;
                           pend_in[OP_SUB]   = 1'b1;
                        end else if (cur_s) begin
                           pend_in[OP_SUB] = 1'b1;
                           cv_in = 1'b0;
                        end
                        inuse_in[rs] = 1'b0;
                     end
                     MODE_PICK: begin
                        if (len_ff == '0) begin
                           cv_in = 1'b0;
                        end else begin
                           ws_in  = cdata[0].slot;
                           cur_in = cdata[0].slot;
                           cv_in  = 1'b1;
                           res_in.chosen_slot   = cdata[0].slot;
                           res_in.chosen_valid  = 1'b1;
                           res_in.wake_on_block = pedantic_ff || (len_ff > LEN_W'(1));
                           pend_in[OP_TAKE] = 1'b1;
                        end
                     end
                     MODE_BLOCKED, MODE_REQUEUE, MODE_NOT_READY: begin
                        if (!cv_ff) begin
                           res_in.status = ST_NO_CURRENT;
                        end else begin
                           ws_in = cur_ff;
                           cv_in = 1'b0;
                           if (r.mode == MODE_BLOCKED) begin
                              pend_in[OP_SYNC1] = 1'b1;
                              pend_in[OP_REM]   = 1'b1;
                              pend_in[OP_SUB]   = 1'b1;
                           end else if (r.mode == MODE_REQUEUE) begin
                              pend_in[OP_RQ]  = 1'b1;
                              pend_in[OP_PUT] = 1'b1;
                           end
                        end
                     end
                     default: begin
                        res_in.status = ST_OK;
                     end
                  endcase
               end
            end
         end
         S_DISP: begin
            if (pend_ff == '0) begin
               state_in = S_OUT;
            end else begin
               op_in = sel;
               pend_in[sel] = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = PROD_W'(mul_a * mul_b);
            neg_in  = mul_neg;
            if (op_ff == OP_SUB) begin
               total_in = total_ff - TOTAL_W'(tick_ff[ws_ff]);
            end else if (op_ff == OP_ADD) begin
               total_in = total_ff + TOTAL_W'(tick_ff[ws_ff]);
            end
            state_in = is_div ? S_DIVGO : S_APPLY;
         end
         S_DIVGO: begin
            if (divisor == '0) begin
               state_in = S_APPLY;
            end else begin
               div_start = 1'b1;
               state_in  = S_WAIT;
            end
         end
         S_WAIT: begin
            if (div_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            state_in = S_DISP;
            case (op_ff)
               OP_NS: ns_in = quo[15:0];
               OP_SYNC1, OP_SYNC2: begin
                  gpass_in = gpass_ff + squo[31:0];
                  last_in  = now_ff;
               end
               OP_SUB, OP_ADD: begin
                  gstride_in = (total_ff == '0) ? 16'(STRIDE_ONE) : quo[15:0];
               end
               OP_MOD: begin
                  mod_we    = 1'b1;
                  remain_we = 1'b1;
                  remain_wd = (divisor == '0) ? 32'(ns_ff) : squo[31:0];
               end
               OP_RQ: begin
                  pass_we = 1'b1;
                  pass_wd = pass_ff[ws_ff] + quo[31:0];
               end
               OP_TAKE: begin
                  ctl.take = 1'b1;
                  queued_in[ws_ff] = 1'b0;
                  if (chain[CLIENTS-1]) begin
                     len_in = len_ff - 1'b1;
                  end
               end
               OP_REM: begin
                  remain_we = 1'b1;
                  remain_wd = pass_ff[ws_ff] - gpass_ff;
               end
               OP_PASS: begin
                  pass_we = 1'b1;
                  pass_wd = gpass_ff + remain_ff[ws_ff];
               end
               OP_PUT: begin
                  if (len_ff < LEN_W'(CLIENTS)) begin
                     ctl.put = 1'b1;
                     queued_in[ws_ff] = 1'b1;
                     len_in = len_ff + 1'b1;
                  end
               end
               default: begin
                  state_in = S_DISP;
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = res_ff;
               rsp_in.queued_count = len_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration port
   always_comb begin
      quantum_in  = quantum_ff;
      pedantic_in = pedantic_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_QUANTUM:  quantum_in  = pwdata[15:0];
            REG_PEDANTIC: pedantic_in = pwdata[0];
            default:      quantum_in  = quantum_ff;
         endcase
      end
   end

   assign prdata = (paddr[2] == REG_PEDANTIC) ? {31'd0, pedantic_ff} : {16'd0, quantum_ff};
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= 16'd11;
         pedantic_ff  <= 1'b1;
         state_ff     <= S_IDLE;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         inuse_ff     <= '0;
         queued_ff    <= '0;
         len_ff       <= '0;
         total_ff     <= '0;
         gstride_ff   <= '0;
         gpass_ff     <= '0;
         last_ff      <= '0;
         cur_ff       <= '0;
         cv_ff        <= 1'b0;
      end else begin
         quantum_ff   <= quantum_in;
         pedantic_ff  <= pedantic_in;
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         inuse_ff     <= inuse_in;
         queued_ff    <= queued_in;
         len_ff       <= len_in;
         total_ff     <= total_in;
         gstride_ff   <= gstride_in;
         gpass_ff     <= gpass_in;
         last_ff      <= last_in;
         cur_ff       <= cur_in;
         cv_ff        <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      ws_ff    <= ws_in;
      t_ff     <= t_in;
      now_ff   <= now_in;
      rt_ff    <= rt_in;
      fresh_ff <= fresh_in;
      ns_ff    <= ns_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      if (mod_we) begin
         tick_ff[ws_ff]   <= t_ff;
         stride_ff[ws_ff] <= ns_ff;
      end
      if (pass_we) begin
         pass_ff[ws_ff] <= pass_wd;
      end
      if (remain_we) begin
         remain_ff[ws_ff] <= remain_wd;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
